// ----- hdl/brms_pkg.sv -----
// Shared types and constants for the bilinear resize engine.
package brms_pkg;

  localparam int DIM_W       = 9;
  localparam int DEN_W       = DIM_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int PIX_W       = 8;
  localparam int HALF_W      = 10;
  localparam int HSUM_SHIFT  = 4;
  localparam int VPROD_SHIFT = 16;

  localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = 9'd96;
  localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = 9'd112;
  localparam logic [DIM_W-1:0] DST_WIDTH_RST  = 9'd96;
  localparam logic [DIM_W-1:0] DST_HEIGHT_RST = 9'd112;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH,
    CFG_SRC_HEIGHT,
    CFG_DST_WIDTH,
    CFG_DST_HEIGHT
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_WGT,
    ST_READ,
    ST_DRAIN,
    ST_HMUL0,
    ST_VMUL0,
    ST_HMUL1,
    ST_VMUL1,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t              opcode;
    logic [7:0]       col;
    logic [7:0]       row;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [HALF_W-1:0] plane0_half;
    logic [HALF_W-1:0] plane1_half;
    logic [HALF_W-1:0] plane2_half;
  } out_item_t;

  typedef struct packed {
    logic       capture;
    logic       div_start;
    logic       wgt_load;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       h_en;
    logic       v_en;
    logic       row_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

// ----- hdl/bilinear_resize_rgb_mean_shift.sv -----
// Top level of the bilinear RGB resize engine with mean shift.
//
//  channel | ports                          | direction | moves
//  in      | in_valid, in_ready, in_data    | input     | load pixel or compute request
//  out     | out_valid, out_ready, out_data | output    | three half-unit planes
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata| input     | dimension register write
//
// A load transaction writes the frame store on acceptance.
// A compute transaction runs the coordinate dividers, one quotient bit per cycle over
// NW = 9 + clog2(MAX_SRC_WIDTH + 1) + WEIGHT_BITS bits on the x axis (MAX_SRC_HEIGHT on y);
// four frame store reads then follow on one port.
// Reset (synchronous, active low) restores the dimension registers; the frame store
// is not cleared. A stalled result holds in the output register while the next
// transaction is accepted; a finished compute waits in its last step until the slot frees.
module bilinear_resize_rgb_mean_shift
  import brms_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int WEIGHT_BITS    = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  brms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brms_dp #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/brms_div.sv -----
// Restoring bit-serial divider: quotient and remainder of a wide dividend by a narrow divisor.
module brms_div
  import brms_pkg::*;
#(
  parameter int NW = 29
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NW-1:0]    dividend,
  input  logic [DEN_W-1:0] den,
  output logic [NW-1:0]    quo,
  output logic [DEN_W-1:0] rem,
  output logic             done
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    qd_r, qd_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial   = {rem_r, qd_r[NW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    qd_nxt  = {qd_r[NW-2:0], ge};
  end

  always_comb begin
    if (start) begin
      cnt_nxt = CNT_W'(NW);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qd_r  <= dividend;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      qd_r  <= qd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo  = qd_r;
  assign rem  = rem_r;
  assign done = (cnt_r == '0);

endmodule

// ----- hdl/brms_ctrl.sv -----
// Sequencer for the resize engine: handshakes, step order and output slot.
module brms_ctrl
  import brms_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  op_t  in_opcode,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] rd_cnt_r, rd_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_opcode == OP_COMPUTE) begin
          state_nxt = ST_START;
        end
      end
      ST_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_WGT;
        end
      end
      ST_WGT: state_nxt = ST_READ;
      ST_READ: begin
        if (rd_cnt_r == 2'd3) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_HMUL0;
      ST_HMUL0: state_nxt = ST_VMUL0;
      ST_VMUL0: state_nxt = ST_HMUL1;
      ST_HMUL1: state_nxt = ST_VMUL1;
      ST_VMUL1: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    rd_cnt_nxt    = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_START: cmd.div_start = 1'b1;
      ST_DIV:   ;
      ST_WGT:   cmd.wgt_load = 1'b1;
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = rd_cnt_r;
        rd_cnt_nxt = rd_cnt_r + 1'b1;
      end
      ST_DRAIN: ;
      ST_HMUL0: cmd.h_en = 1'b1;
      ST_VMUL0: cmd.v_en = 1'b1;
      ST_HMUL1: begin
        cmd.h_en    = 1'b1;
        cmd.row_sel = 1'b1;
      end
      ST_VMUL1: begin
        cmd.v_en    = 1'b1;
        cmd.row_sel = 1'b1;
      end
      ST_OUT:   cmd.out_load = out_free;
      default:  ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // never overwrite a result that has not been taken
  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while occupied");

  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_COMPUTE) |=> state_r == ST_START)
    else $error("compute transaction did not start the divider");

  a_div_to_wgt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_done) |=> state_r == ST_WGT)
    else $error("divider finish not followed by weight load");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside the output step");

endmodule

// ----- hdl/brms_dp.sv -----
// Datapath: config registers, frame store, coordinate dividers, weights and MAC.
module brms_dp
  import brms_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int WEIGHT_BITS    = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  cmd_t                 cmd,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  output sts_t                 sts,
  output out_item_t            out_data
);

  localparam int XW    = $clog2(MAX_SRC_WIDTH);
  localparam int YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int SWW   = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW   = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int PXW   = DIM_W + SWW;
  localparam int PYW   = DIM_W + SHW;
  localparam int NXW   = PXW + WEIGHT_BITS;
  localparam int NYW   = PYW + WEIGHT_BITS;
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = WEIGHT_BITS + 1;
  localparam int CW    = WEIGHT_BITS + PIX_W;
  localparam int CHW   = CW - HSUM_SHIFT;
  localparam int PRW   = CHW + WW;
  localparam int TW    = PRW - VPROD_SHIFT;
  localparam int ACW   = (TW + 2 > HALF_W) ? TW + 2 : HALF_W;
  localparam logic [WW-1:0] W_ONE = WW'(1 << WEIGHT_BITS);

  // configuration
  logic [DIM_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [SWW-1:0]   sw;
  logic [SHW-1:0]   sh;
  logic [DIM_W-1:0] dw, dh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SRC_WIDTH_RST;
      src_h_r <= SRC_HEIGHT_RST;
      dst_w_r <= DST_WIDTH_RST;
      dst_h_r <= DST_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_w_r <= cfg_wdata;
        CFG_SRC_HEIGHT: src_h_r <= cfg_wdata;
        CFG_DST_WIDTH:  dst_w_r <= cfg_wdata;
        CFG_DST_HEIGHT: dst_h_r <= cfg_wdata;
      endcase
    end
  end

  // zero acts as one, source saturates at the store size
  always_comb begin
    if (src_w_r == '0) begin
      sw = SWW'(1);
    end else if (32'(src_w_r) > 32'(MAX_SRC_WIDTH)) begin
      sw = SWW'(MAX_SRC_WIDTH);
    end else begin
      sw = SWW'(src_w_r);
    end
    if (src_h_r == '0) begin
      sh = SHW'(1);
    end else if (32'(src_h_r) > 32'(MAX_SRC_HEIGHT)) begin
      sh = SHW'(MAX_SRC_HEIGHT);
    end else begin
      sh = SHW'(src_h_r);
    end
    dw = (dst_w_r == '0) ? DIM_W'(1) : dst_w_r;
    dh = (dst_h_r == '0) ? DIM_W'(1) : dst_h_r;
  end

  // transaction capture and frame store
  logic [7:0]   col_r, row_r;
  logic         st_wr;
  logic [AW-1:0] st_waddr, rd_addr;
  logic [3*PIX_W-1:0] mem [DEPTH];
  logic [3*PIX_W-1:0] mem_q_r;

  assign st_wr = cmd.capture && in_data.opcode == OP_LOAD
              && (32'(in_data.col) < 32'(MAX_SRC_WIDTH))
              && (32'(in_data.row) < 32'(MAX_SRC_HEIGHT));
  assign st_waddr = AW'(YW'(in_data.row)) * AW'(MAX_SRC_WIDTH) + AW'(XW'(in_data.col));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r <= in_data.col;
      row_r <= in_data.row;
    end
  end

  always_ff @(posedge clk) begin
    if (st_wr) begin
      mem[st_waddr] <= {in_data.blue, in_data.green, in_data.red};
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // source coordinate: ((2d+1)*src - dst) / (2*dst), fraction carried on WEIGHT_BITS
  logic [PXW-1:0]   pos_x, num_x;
  logic [PYW-1:0]   pos_y, num_y;
  logic [NXW-1:0]   quo_x;
  logic [NYW-1:0]   quo_y;
  logic [DEN_W-1:0] rem_x, rem_y;
  logic             done_x, done_y;

  always_comb begin
    pos_x = PXW'(PXW'({col_r, 1'b1}) * PXW'(sw));
    pos_y = PYW'(PYW'({row_r, 1'b1}) * PYW'(sh));
    num_x = (pos_x >= PXW'(dw)) ? pos_x - PXW'(dw) : '0;
    num_y = (pos_y >= PYW'(dh)) ? pos_y - PYW'(dh) : '0;
  end

  brms_div #(.NW(NXW)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({num_x, {WEIGHT_BITS{1'b0}}}),
    .den      ({dw, 1'b0}),
    .quo      (quo_x),
    .rem      (rem_x),
    .done     (done_x)
  );

  brms_div #(.NW(NYW)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({num_y, {WEIGHT_BITS{1'b0}}}),
    .den      ({dh, 1'b0}),
    .quo      (quo_y),
    .rem      (rem_y),
    .done     (done_y)
  );

  assign sts.div_done = done_x && done_y;

  // index, clamp and weights
  logic [PXW-1:0]         sx;
  logic [PYW-1:0]         sy;
  logic [WEIGHT_BITS-1:0] fx, fy;
  logic                   clamp_x, clamp_y;
  logic [XW-1:0]          ix, ix_r;
  logic [YW-1:0]          iy, iy_r;
  logic [WW-1:0]          w0x, w0y, w0x_r, w0y_r;
  logic [WEIGHT_BITS-1:0] w1x, w1y, w1x_r, w1y_r;
  logic                   x1ok_r, y1ok_r;

  always_comb begin
    sx      = quo_x[NXW-1:WEIGHT_BITS];
    sy      = quo_y[NYW-1:WEIGHT_BITS];
    fx      = quo_x[WEIGHT_BITS-1:0];
    fy      = quo_y[WEIGHT_BITS-1:0];
    clamp_x = ({1'b0, sx} + 1'b1) >= (PXW + 1)'(sw);
    clamp_y = ({1'b0, sy} + 1'b1) >= (PYW + 1)'(sh);
    ix      = clamp_x ? XW'(sw - 1'b1) : XW'(sx);
    iy      = clamp_y ? YW'(sh - 1'b1) : YW'(sy);
    // 1 - frac: exact complement, one less when the division left a remainder
    w1x     = clamp_x ? '0 : fx;
    w1y     = clamp_y ? '0 : fy;
    w0x     = clamp_x ? W_ONE : W_ONE - WW'(fx) - WW'(rem_x != '0);
    w0y     = clamp_y ? W_ONE : W_ONE - WW'(fy) - WW'(rem_y != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.wgt_load) begin
      ix_r   <= ix;
      iy_r   <= iy;
      w0x_r  <= w0x;
      w1x_r  <= w1x;
      w0y_r  <= w0y;
      w1y_r  <= w1y;
      x1ok_r <= (32'(ix) + 1) < 32'(sw);
      y1ok_r <= (32'(iy) + 1) < 32'(sh);
    end
  end

  // neighbor fetch; missing right or bottom neighbor reads as zero
  logic [XW-1:0]      rx;
  logic [YW-1:0]      ry;
  logic               rd_zero;
  logic               rd_pend_r;
  logic [1:0]         rd_sel_r;
  logic               rd_zero_r;
  logic [3*PIX_W-1:0] px_r [4];

  always_comb begin
    rx      = (cmd.rd_sel[0] && x1ok_r) ? XW'(ix_r + 1'b1) : ix_r;
    ry      = (cmd.rd_sel[1] && y1ok_r) ? YW'(iy_r + 1'b1) : iy_r;
    rd_zero = (cmd.rd_sel[0] && !x1ok_r) || (cmd.rd_sel[1] && !y1ok_r);
    rd_addr = AW'(ry) * AW'(MAX_SRC_WIDTH) + AW'(rx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_sel_r  <= cmd.rd_sel;
      rd_zero_r <= rd_zero;
    end
    if (rd_pend_r) begin
      px_r[rd_sel_r] <= rd_zero_r ? '0 : mem_q_r;
    end
  end

  // horizontal blend, then vertical weight and accumulate, one source row per pass
  logic [3*PIX_W-1:0] pa, pb;
  logic [WW-1:0]      wy;
  logic [CW:0]        c_sum [3];
  logic [CW-1:0]      c_r [3];
  logic [PRW-1:0]     prod [3];
  logic [ACW-1:0]     acc_nxt [3];
  logic [ACW-1:0]     acc_r [3];

  always_comb begin
    pa = cmd.row_sel ? px_r[2] : px_r[0];
    pb = cmd.row_sel ? px_r[3] : px_r[1];
    wy = cmd.row_sel ? {1'b0, w1y_r} : w0y_r;
    for (int ch = 0; ch < 3; ch++) begin
      c_sum[ch] = (CW + 1)'(w0x_r) * (CW + 1)'(pa[PIX_W*ch +: PIX_W])
                + (CW + 1)'(w1x_r) * (CW + 1)'(pb[PIX_W*ch +: PIX_W]);
      prod[ch]  = PRW'(c_r[ch][CW-1:HSUM_SHIFT]) * PRW'(wy);
      acc_nxt[ch] = (cmd.row_sel ? acc_r[ch] : '0) + ACW'(prod[ch][PRW-1:VPROD_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.h_en) begin
        c_r[ch] <= c_sum[ch][CW-1:0];
      end
      if (cmd.v_en) begin
        acc_r[ch] <= acc_nxt[ch];
      end
    end
  end

  // round, wrap to a byte, add 127.5 in half units
  function automatic logic [HALF_W-1:0] to_half(logic [ACW-1:0] acc);
    logic [ACW-1:0] rnd;
    rnd = acc + ACW'(2);
    return {1'b0, rnd[PIX_W+1:2], 1'b1} + HALF_W'(254);
  endfunction

  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.plane0_half <= to_half(acc_r[0]);
      out_r.plane1_half <= to_half(acc_r[1]);
      out_r.plane2_half <= to_half(acc_r[2]);
    end
  end

  assign out_data = out_r;

endmodule
